>>> hdl/sqgr_pkg.sv
`default_nettype none

package sqgr_pkg;

    localparam int SEQ_W      = 64;
    localparam int CNT_W      = 16;
    localparam int LEN_W      = 16;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 200;
    localparam int OUT_USER_W = 3;

    localparam logic [LEN_W-1:0]  HEADER_BYTES    = LEN_W'(20);
    localparam logic [CNT_W-1:0]  END_OF_SESSION  = '1;
    localparam logic [TICK_W-1:0] TICK_MAX        = '1;
    localparam logic [TICK_W-1:0] DEFAULT_TIMEOUT = TICK_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_SEQUENCE = 1'b0,
        CFG_TIMEOUT_TICKS  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_UNKNOWN = 2'd0,
        MODE_SYNC    = 2'd1,
        MODE_RECOVER = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_TRUNCATED = 3'd0,
        ST_DELIVERED = 3'd1,
        ST_STALE     = 3'd2,
        ST_GAP       = 3'd3,
        ST_SESSION   = 3'd4
    } status_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  next_expected;
        mode_t             mode;
        logic [SEQ_W-1:0]  recovery_end;
        logic [TICK_W-1:0] ticks;
    } state_t;

    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  seq;
        logic [CNT_W-1:0]  count;
        logic [LEN_W-1:0]  len;
    } beat_t;

    typedef struct packed {
        status_t           status;
        logic              deliver;
        logic              request_valid;
        logic [SEQ_W-1:0]  request_sequence;
        logic [SEQ_W-1:0]  expected_now;
        mode_t             sync_mode;
        logic [SEQ_W-1:0]  window_end;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/sequenced_packet_gap_recovery_top.sv
// path: input beat to input register, then its result beat to the result register
// throughput: one beat per cycle while m_ takes result beats, set by the single
//   compare/add pass from input to result register; tick beats give no result beat
// reset: synchronous, active low on aresetn; clears both valids, mode to unknown,
//   expected and window end to zero, tick count saturated, timeout back to 1000
`default_nettype none

module sequenced_packet_gap_recovery_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // header_sequence[63:0], header_count[79:64], packet_length[95:80]
    input  wire logic [sqgr_pkg::IN_DATA_W-1:0]      s_tdata,
    // kind[0]
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // deliver[0], request_valid[1], request_sequence[65:2], expected_now[129:66],
    // sync_mode[131:130], window_end[195:132], zero fill[199:196]
    output logic [sqgr_pkg::OUT_DATA_W-1:0]          m_tdata,
    // status[2:0]
    output logic [sqgr_pkg::OUT_USER_W-1:0]          m_tuser,
    input  wire logic                                cfg_wr_en,
    input  wire logic [sqgr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sqgr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic                          in_valid_reg;
    sqgr_pkg::beat_t               in_beat_reg;
    sqgr_pkg::state_t              state_reg;
    sqgr_pkg::state_t              state_next;
    logic [sqgr_pkg::TICK_W-1:0]   timeout_reg;
    logic                          m_valid_reg;
    sqgr_pkg::result_t             result_reg;
    sqgr_pkg::result_t             result_next;
    logic                          has_result;
    logic                          advance;
    logic                          out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (in_beat_reg.kind || out_free);
    assign s_tready = !in_valid_reg || advance;

    sqgr_step u_step (
        .beat          (in_beat_reg),
        .cur           (state_reg),
        .timeout_ticks (timeout_reg),
        .nxt           (state_next),
        .has_result    (has_result),
        .res           (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_beat_reg.kind  <= s_tuser;
            in_beat_reg.seq   <= s_tdata[63:0];
            in_beat_reg.count <= s_tdata[79:64];
            in_beat_reg.len   <= s_tdata[95:80];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.next_expected <= '0;
            state_reg.mode          <= sqgr_pkg::MODE_UNKNOWN;
            state_reg.recovery_end  <= '0;
            state_reg.ticks         <= sqgr_pkg::TICK_MAX;
            timeout_reg             <= sqgr_pkg::DEFAULT_TIMEOUT;
        end else if (cfg_wr_en) begin
            unique case (sqgr_pkg::cfg_index_t'(cfg_index))
                sqgr_pkg::CFG_START_SEQUENCE: state_reg.next_expected <= cfg_wdata;
                sqgr_pkg::CFG_TIMEOUT_TICKS:  timeout_reg <= cfg_wdata[sqgr_pkg::TICK_W-1:0];
                default: ;
            endcase
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && has_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = result_reg.status;
    assign m_tdata  = {4'b0000,
                       result_reg.window_end,
                       result_reg.sync_mode,
                       result_reg.expected_now,
                       result_reg.request_sequence,
                       result_reg.request_valid,
                       result_reg.deliver};

`ifndef SYNTHESIS
    a_result_from_header: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(advance && !in_beat_reg.kind))
        else $error("result beat without a header beat");

    a_gap_recovers: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.status == sqgr_pkg::ST_GAP)
            |-> result_reg.sync_mode == sqgr_pkg::MODE_RECOVER)
        else $error("gap reported outside recovery");

    a_window_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.sync_mode != sqgr_pkg::MODE_RECOVER)
            |-> result_reg.window_end == '0)
        else $error("window end set while not recovering");

    a_deliver_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (result_reg.deliver == (result_reg.status == sqgr_pkg::ST_DELIVERED)))
        else $error("deliver flag disagrees with status");
`endif

endmodule

`default_nettype wire

>>> hdl/sqgr_step.sv
`default_nettype none

module sqgr_step (
    input  sqgr_pkg::beat_t                   beat,
    input  sqgr_pkg::state_t                  cur,
    input  logic [sqgr_pkg::TICK_W-1:0]       timeout_ticks,
    output sqgr_pkg::state_t                  nxt,
    output logic                              has_result,
    output sqgr_pkg::result_t                 res
);

    logic                          ended;
    logic [sqgr_pkg::CNT_W-1:0]    cnt;
    logic [sqgr_pkg::SEQ_W-1:0]    next_seq;
    logic [sqgr_pkg::SEQ_W-1:0]    expect_seq;
    logic                          req;
    logic [sqgr_pkg::SEQ_W-1:0]    req_seq;
    sqgr_pkg::status_t             status;
    logic                          deliver;

    always_comb begin
        nxt        = cur;
        has_result = 1'b0;
        req        = 1'b0;
        req_seq    = '0;
        deliver    = 1'b0;
        status     = sqgr_pkg::ST_TRUNCATED;
        ended      = (beat.count == sqgr_pkg::END_OF_SESSION);
        cnt        = ended ? '0 : beat.count;
        next_seq   = beat.seq + {{(sqgr_pkg::SEQ_W-sqgr_pkg::CNT_W){1'b0}}, cnt};
        expect_seq = (cur.next_expected == '0) ? beat.seq : cur.next_expected;

        if (beat.kind) begin
            if (cur.ticks != sqgr_pkg::TICK_MAX) begin
                nxt.ticks = cur.ticks + 1'b1;
            end
        end else begin
            has_result = 1'b1;
            if (beat.len >= sqgr_pkg::HEADER_BYTES) begin
                nxt.next_expected = expect_seq;
                if (beat.seq > expect_seq) begin
                    status = sqgr_pkg::ST_GAP;
                    if (cur.mode != sqgr_pkg::MODE_RECOVER) begin
                        nxt.recovery_end = next_seq;
                        nxt.mode         = sqgr_pkg::MODE_RECOVER;
                        req              = 1'b1;
                        req_seq          = expect_seq;
                    end else begin
                        if (next_seq > cur.recovery_end) begin
                            nxt.recovery_end = next_seq;
                        end
                        if (cur.ticks >= timeout_ticks) begin
                            req     = 1'b1;
                            req_seq = expect_seq;
                        end
                    end
                end else if (beat.seq < expect_seq) begin
                    status = sqgr_pkg::ST_STALE;
                end else begin
                    if (cur.mode == sqgr_pkg::MODE_RECOVER) begin
                        if (cur.recovery_end == next_seq) begin
                            nxt.mode         = sqgr_pkg::MODE_SYNC;
                            nxt.recovery_end = '0;
                        end else begin
                            req     = 1'b1;
                            req_seq = next_seq;
                        end
                    end else begin
                        if (cur.mode == sqgr_pkg::MODE_UNKNOWN) begin
                            nxt.recovery_end = '0;
                        end
                        nxt.mode = sqgr_pkg::MODE_SYNC;
                    end
                    if (ended) begin
                        status = sqgr_pkg::ST_SESSION;
                    end else begin
                        status            = sqgr_pkg::ST_DELIVERED;
                        deliver           = 1'b1;
                        nxt.next_expected = expect_seq + 1'b1;
                    end
                end
                if (req) begin
                    nxt.ticks = '0;
                end
            end
        end

        res.status           = status;
        res.deliver          = deliver;
        res.request_valid    = req;
        res.request_sequence = req_seq;
        res.expected_now     = nxt.next_expected;
        res.sync_mode        = nxt.mode;
        res.window_end       = nxt.recovery_end;
    end

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sqgr_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // header_sequence[63:0], header_count[79:64], packet_length[95:80]
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // kind[0]
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // deliver[0], request_valid[1], request_sequence[65:2], expected_now[129:66],
    // sync_mode[131:130], window_end[195:132], zero fill[199:196]
    logic [OUT_DATA_W-1:0] m_tdata;
    // status[2:0]
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    sequenced_packet_gap_recovery_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // receiver-side sequencing copy
    logic [SEQ_W-1:0]  seq_next = '0;
    logic [SEQ_W-1:0]  seq_window = '0;
    mode_t             seq_mode = MODE_UNKNOWN;
    logic [TICK_W-1:0] tick_count = TICK_MAX;
    logic [TICK_W-1:0] tick_limit = DEFAULT_TIMEOUT;

    result_t expected_reports[$];
    int      fail_count = 0;
    logic    steady = 1'b0;
    int      rx_run = 0;

    task automatic track_sequence(input logic kind, input logic [SEQ_W-1:0] seq,
                                  input logic [CNT_W-1:0] count,
                                  input logic [LEN_W-1:0] len);
        result_t          r;
        logic             ended;
        logic [CNT_W-1:0] msgs;
        logic [SEQ_W-1:0] upto;
        if (kind) begin
            if (tick_count != TICK_MAX) tick_count = tick_count + 1'b1;
        end else begin
            r = '0;
            if (len < HEADER_BYTES) begin
                r.status = ST_TRUNCATED;
            end else begin
                ended = (count == END_OF_SESSION);
                msgs = ended ? '0 : count;
                upto = seq + SEQ_W'(msgs);
                if (seq_next == '0) seq_next = seq;
                if (seq > seq_next) begin
                    r.status = ST_GAP;
                    if (seq_mode != MODE_RECOVER) begin
                        seq_window = upto;
                        seq_mode = MODE_RECOVER;
                        r.request_valid = 1'b1;
                        r.request_sequence = seq_next;
                    end else begin
                        if (upto > seq_window) seq_window = upto;
                        if (tick_count >= tick_limit) begin
                            r.request_valid = 1'b1;
                            r.request_sequence = seq_next;
                        end
                    end
                end else if (seq < seq_next) begin
                    r.status = ST_STALE;
                end else begin
                    case (seq_mode)
                        MODE_UNKNOWN: begin
                            seq_mode = MODE_SYNC;
                            seq_window = '0;
                        end
                        MODE_RECOVER: begin
                            if (seq_window == upto) begin
                                seq_mode = MODE_SYNC;
                                seq_window = '0;
                            end else begin
                                r.request_valid = 1'b1;
                                r.request_sequence = upto;
                            end
                        end
                        default: seq_mode = MODE_SYNC;
                    endcase
                    if (ended) begin
                        r.status = ST_SESSION;
                    end else begin
                        r.status = ST_DELIVERED;
                        r.deliver = 1'b1;
                        seq_next = seq_next + 1'b1;
                    end
                end
                if (r.request_valid) tick_count = '0;
            end
            r.expected_now = seq_next;
            r.sync_mode = seq_mode;
            r.window_end = seq_window;
            expected_reports.push_back(r);
        end
    endtask

    task automatic send_beat(input logic kind, input logic [SEQ_W-1:0] seq,
                             input logic [CNT_W-1:0] count, input logic [LEN_W-1:0] len);
        int gap;
        gap = 0;
        if (!steady) begin
            if ($urandom_range(0, 9) == 9) gap = $urandom_range(5, 30);
            else if ($urandom_range(0, 1) == 1) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {len, count, seq};
        do @(posedge aclk); while (!s_tready);
        track_sequence(kind, seq, count, len);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // call only after drain
    task automatic set_config(input logic load_start, input logic [SEQ_W-1:0] start,
                              input logic load_limit, input logic [TICK_W-1:0] limit);
        if (load_start) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_START_SEQUENCE;
            cfg_wdata <= start;
            @(posedge aclk);
            seq_next = start;
        end
        if (load_limit) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_TIMEOUT_TICKS;
            cfg_wdata <= CFG_DATA_W'(limit);
            @(posedge aclk);
            tick_limit = limit;
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_power_up();
        send_beat(1'b1, '1, '1, '1);
        send_beat(1'b0, '1, '1, 16'd19);
        send_beat(1'b0, 64'd100, 16'd1, 16'd20);
        send_beat(1'b0, 64'd101, END_OF_SESSION, '1);
        send_beat(1'b0, 64'd50, 16'd1, 16'd64);
    endtask

    task automatic test_gap_recovery();
        send_beat(1'b0, 64'd110, 16'd5, 16'd100);
        send_beat(1'b0, 64'd120, 16'd2, 16'd100);
        drain();
        set_config(1'b0, '0, 1'b1, 16'd2);
        send_beat(1'b1, '0, '0, '0);
        send_beat(1'b1, '0, '0, '0);
        send_beat(1'b0, 64'd130, 16'd0, 16'd40);
        send_beat(1'b1, '0, '0, '0);
        send_beat(1'b0, 64'd131, 16'd0, 16'd20);
        send_beat(1'b0, 64'd101, 16'd1, 16'd60);
        send_beat(1'b0, 64'd102, 16'd29, 16'd60);
        send_beat(1'b0, 64'd0, 16'd0, 16'd20);
    endtask

    task automatic test_sequence_wrap();
        drain();
        set_config(1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 16'hFFFF);
        send_beat(1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 16'd3, 16'd80);
        send_beat(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 16'd80);
        // expected wrapped to zero, so the next header is adopted
        send_beat(1'b0, 64'd5, 16'hFFFE, 16'd80);
        // window end wraps to zero while recovering
        send_beat(1'b0, 64'hFFFF_FFFF_FFFF_FFF0, 16'h0010, 16'd80);
        send_beat(1'b0, 64'd6, 16'd1, 16'd80);
    endtask

    task automatic test_tick_timeout();
        drain();
        set_config(1'b0, '0, 1'b1, 16'd8);
        steady = 1'b1;
        repeat (7) send_beat(1'b1, '0, '0, '0);
        steady = 1'b0;
        // one tick short of the timeout, then exactly at it
        send_beat(1'b0, seq_next + 64'd3, 16'd1, 16'd90);
        send_beat(1'b1, '0, '0, '0);
        send_beat(1'b0, seq_next + 64'd4, 16'd1, 16'd90);
    endtask

    task automatic test_random_traffic();
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] start;
        logic [CNT_W-1:0] count;
        logic [LEN_W-1:0] len;
        logic [TICK_W-1:0] limit;
        logic load_start;
        int pick;
        for (int phase = 0; phase < 5; phase++) begin
            drain();
            load_start = 1'b1;
            case (phase)
                0: begin
                    start = '0;
                    limit = 16'd1;
                end
                1: begin
                    start = '1;
                    limit = 16'hFFFF;
                end
                2: begin
                    load_start = 1'b0;
                    start = '0;
                    limit = TICK_W'($urandom_range(1, 8));
                end
                3: begin
                    start = {$urandom, $urandom};
                    limit = DEFAULT_TIMEOUT;
                end
                default: begin
                    start = '1 - SEQ_W'($urandom_range(0, 30));
                    limit = TICK_W'($urandom_range(1, 65535));
                end
            endcase
            set_config(load_start, start, 1'b1, limit);
            for (int i = 0; i < 130; i++) begin
                steady = (i >= 60 && i < 100);
                if (phase == 2 && i == 110) drain();
                pick = $urandom_range(0, 99);
                seq = seq_next;
                count = CNT_W'($urandom_range(1, 4));
                len = LEN_W'($urandom_range(20, 1500));
                if (pick < 12) begin
                    repeat ($urandom_range(1, 10))
                        send_beat(1'b1, {$urandom, $urandom}, CNT_W'($urandom),
                                  LEN_W'($urandom));
                end else begin
                    if (pick < 55) begin
                        if (seq_mode == MODE_RECOVER && $urandom_range(0, 1) == 1)
                            count = CNT_W'(seq_window - seq_next);
                    end else if (pick < 72) begin
                        seq = seq_next + SEQ_W'($urandom_range(1, 20));
                    end else if (pick < 80) begin
                        seq = seq_next - SEQ_W'($urandom_range(1, 20));
                    end else if (pick < 86) begin
                        len = LEN_W'($urandom_range(0, 19));
                    end else if (pick < 90) begin
                        count = END_OF_SESSION;
                    end else begin
                        seq = {$urandom, $urandom};
                        count = CNT_W'($urandom);
                        len = LEN_W'($urandom);
                    end
                    send_beat(1'b0, seq, count, len);
                end
            end
            steady = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        if (rx_run > 0) begin
            rx_run--;
        end else if (steady || $urandom_range(0, 3) != 0) begin
            m_tready <= 1'b1;
            rx_run = $urandom_range(0, 12);
        end else begin
            m_tready <= 1'b0;
            rx_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        end
    end

    always @(posedge aclk) begin : report_check
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tuser);
            got.deliver = m_tdata[0];
            got.request_valid = m_tdata[1];
            got.request_sequence = m_tdata[65:2];
            got.expected_now = m_tdata[129:66];
            got.sync_mode = mode_t'(m_tdata[131:130]);
            got.window_end = m_tdata[195:132];
            if (expected_reports.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = expected_reports.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.deliver !== want.deliver) begin
                    $error("deliver: expected %0b, got %0b", want.deliver, got.deliver);
                    fail_count++;
                end
                if (got.request_valid !== want.request_valid) begin
                    $error("request_valid: expected %0b, got %0b",
                           want.request_valid, got.request_valid);
                    fail_count++;
                end
                if (got.request_sequence !== want.request_sequence) begin
                    $error("request_sequence: expected %0h, got %0h",
                           want.request_sequence, got.request_sequence);
                    fail_count++;
                end
                if (got.expected_now !== want.expected_now) begin
                    $error("expected_now: expected %0h, got %0h",
                           want.expected_now, got.expected_now);
                    fail_count++;
                end
                if (got.sync_mode !== want.sync_mode) begin
                    $error("sync_mode: expected %0d, got %0d", want.sync_mode, got.sync_mode);
                    fail_count++;
                end
                if (got.window_end !== want.window_end) begin
                    $error("window_end: expected %0h, got %0h",
                           want.window_end, got.window_end);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_power_up();
        test_gap_recovery();
        test_sequence_wrap();
        test_tick_timeout();
        test_random_traffic();
        drain();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
